>>> rtl/core/itda_pkg.sv
// Shared constants, types and helpers for the decimal ASCII converter.
// No dependencies; every other file in rtl/core imports this package.
package itda_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_VALUE_BITS = 32;

	// Binary bits folded into BCD per pipeline stage.
	localparam int BITS_PER_STAGE = 8;

	localparam int FW_W   = 7;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

	// Per-item info that rides along the conversion pipeline.
	typedef struct packed {
		logic            neg;
		logic [FW_W-1:0] width;
	} meta_t;

	// Decimal digits needed for any magnitude below 2^bits
	// (1233/4096 approximates log10(2) from below for bits up to 64).
	function automatic int dec_digits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

endpackage

>>> rtl/core/itda_dabble_stage.sv
// One double-dabble pipeline stage: folds BITS_PER_STAGE binary bits into BCD.
// Depends on itda_pkg.
module itda_dabble_stage
	import itda_pkg::*;
#(
	parameter int NUM_DIGITS = 10,
	parameter int BIN_W      = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [4*NUM_DIGITS-1:0] in_bcd,
	input  logic [BIN_W-1:0]        in_bin,
	input  meta_t                   in_meta,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [4*NUM_DIGITS-1:0] out_bcd,
	output logic [BIN_W-1:0]        out_bin,
	output meta_t                   out_meta
);

	localparam int BCD_W = 4 * NUM_DIGITS;

	logic             v_sn;
	logic [BCD_W-1:0] bcd_sn;
	logic [BIN_W-1:0] bin_sn;
	meta_t            meta_sn;
	logic [BCD_W-1:0] bcd_nx;
	logic [BIN_W-1:0] bin_nx;

	// add-3 then shift, once per bit
	always_comb begin
		bcd_nx = in_bcd;
		bin_nx = in_bin;
		for (int j = 0; j < BITS_PER_STAGE; j++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (bcd_nx[4*d +: 4] >= 4'd5) begin
					bcd_nx[4*d +: 4] = bcd_nx[4*d +: 4] + 4'd3;
				end
			end
			bcd_nx = {bcd_nx[BCD_W-2:0], bin_nx[BIN_W-1]};
			bin_nx = {bin_nx[BIN_W-2:0], 1'b0};
		end
	end

	assign in_ready = !v_sn || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (in_ready) begin
			v_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_sn  <= bcd_nx;
			bin_sn  <= bin_nx;
			meta_sn <= in_meta;
		end
	end

	assign out_valid = v_sn;
	assign out_bcd   = bcd_sn;
	assign out_bin   = bin_sn;
	assign out_meta  = meta_sn;

endmodule

>>> rtl/core/itda_emit.sv
// Character emitter: walks one converted item out one character per cycle while out_stall is low.
// Depends on itda_pkg.
module itda_emit
	import itda_pkg::*;
#(
	parameter int NUM_DIGITS = 10,
	parameter int LEN_W      = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [4*NUM_DIGITS-1:0] in_bcd,
	input  meta_t                   in_meta,
	input  logic [LEN_W-1:0]        in_len,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHAR_W-1:0]       character,
	output logic                    last
);

	localparam int DIDX_W = $clog2(NUM_DIGITS);

	logic                    busy_q;
	logic [FW_W-1:0]         k_q;
	logic [4*NUM_DIGITS-1:0] bcd_q;
	logic                    neg_q;
	logic [FW_W-1:0]         width_q;
	logic [LEN_W-1:0]        len_q;
	logic                    out_valid_q;
	logic [CHAR_W-1:0]       char_q;
	logic                    last_q;

	logic                    gen;
	logic                    last_now;
	logic                    load;
	logic [FW_W-1:0]         len_x;
	logic [FW_W-1:0]         didx;
	logic [CHAR_W-1:0]       char_nx;

	assign len_x    = FW_W'(len_q);
	assign didx     = len_x - 7'd1 - k_q;
	assign last_now = (k_q == width_q - 7'd1);
	assign gen      = busy_q && (!out_valid_q || !out_stall);
	assign in_ready = !busy_q || (gen && last_now);
	assign load     = in_valid && in_ready;

	always_comb begin
		if (k_q >= len_x) begin
			char_nx = ASCII_SPACE;
		end else if (neg_q && (k_q == '0)) begin
			char_nx = ASCII_MINUS;
		end else begin
			char_nx = ASCII_ZERO + {4'b0000, bcd_q[4*didx[DIDX_W-1:0] +: 4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (gen) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// a new item takes over the cycle the previous one ends
			if (load) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (gen) begin
				k_q <= k_q + 7'd1;
				if (last_now) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen) begin
			char_q <= char_nx;
			last_q <= last_now;
		end
		if (load) begin
			bcd_q   <= in_bcd;
			neg_q   <= in_meta.neg;
			width_q <= in_meta.width;
			len_q   <= in_len;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

>>> rtl/core/int_to_decimal_ascii_padded.sv
// Top level of the signed integer to fixed-width decimal ASCII converter.
// Depends on itda_pkg, itda_dabble_stage and itda_emit.
//
// Each accepted item (value, field_width) produces exactly min(field_width,
// MAX_WIDTH) characters, most significant first: an optional '-', the decimal
// digits, then space padding, or the leading part of that text when the field
// is too narrow. The final character carries last = 1. Items with
// field_width == 0 are accepted and dropped without output. The output
// register emits one character per cycle while out_stall is low; the next
// item is loaded in the same cycle the previous item's final character is
// produced, so consecutive fields leave no gap. The conversion pipeline
// (input stage, ceil(VALUE_BITS/8) double-dabble stages of eight bits each,
// a length stage) accepts a new item every cycle unless in_stall is raised,
// and buffers items while the emitter is busy.
module int_to_decimal_ascii_padded
	import itda_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic [FW_W-1:0]              field_width,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [CHAR_W-1:0]            character,
	output logic                         last
);

	localparam int NUM_DIGITS = dec_digits(VALUE_BITS);
	localparam int NUM_STAGES = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
	localparam int BIN_W      = NUM_STAGES * BITS_PER_STAGE;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int LEN_W      = $clog2(NUM_DIGITS + 2);

	// ---- input stage: sign, magnitude, width saturation ----
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [FW_W-1:0]       width_sat;
	logic                  ready_s1;
	logic                  v_s1;
	logic [BIN_W-1:0]      bin_s1;
	meta_t                 meta_s1;

	assign raw = value;
	// two's complement negate; the most negative value maps to 2^(VALUE_BITS-1)
	assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign width_sat = ({1'b0, field_width} > 8'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH)
		: field_width;

	// chain links: index 0 is the input stage, NUM_STAGES is the dabble output
	logic             v_c    [NUM_STAGES+1];
	logic             rdy_c  [NUM_STAGES+1];
	logic [BIN_W-1:0] bin_c  [NUM_STAGES+1];
	logic [BCD_W-1:0] bcd_c  [NUM_STAGES+1];
	meta_t            meta_c [NUM_STAGES+1];

	assign ready_s1 = !v_s1 || rdy_c[0];
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			// zero-width items are taken and dropped here
			v_s1 <= in_valid && (field_width != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			bin_s1        <= BIN_W'(mag);
			meta_s1.neg   <= raw[VALUE_BITS-1];
			meta_s1.width <= width_sat;
		end
	end

	assign v_c[0]    = v_s1;
	assign bin_c[0]  = bin_s1;
	assign bcd_c[0]  = '0;
	assign meta_c[0] = meta_s1;

	// ---- double-dabble stages ----
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_dab
		itda_dabble_stage #(
			.NUM_DIGITS (NUM_DIGITS),
			.BIN_W      (BIN_W)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v_c[i]),
			.in_ready  (rdy_c[i]),
			.in_bcd    (bcd_c[i]),
			.in_bin    (bin_c[i]),
			.in_meta   (meta_c[i]),
			.out_valid (v_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.out_bcd   (bcd_c[i+1]),
			.out_bin   (bin_c[i+1]),
			.out_meta  (meta_c[i+1])
		);
	end

	// ---- length stage: count significant digits, add the sign ----
	logic             v_sl;
	logic [BCD_W-1:0] bcd_sl;
	meta_t            meta_sl;
	logic [LEN_W-1:0] len_sl;
	logic [LEN_W-1:0] ndig;
	logic [LEN_W-1:0] len_nx;
	logic             emit_ready;
	logic             ready_sl;

	always_comb begin
		ndig = LEN_W'(1);
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (bcd_c[NUM_STAGES][4*d +: 4] != 4'd0) begin
				ndig = LEN_W'(d + 1);
			end
		end
		len_nx = ndig + LEN_W'(meta_c[NUM_STAGES].neg);
	end

	assign ready_sl          = !v_sl || emit_ready;
	assign rdy_c[NUM_STAGES] = ready_sl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sl <= 1'b0;
		end else if (ready_sl) begin
			v_sl <= v_c[NUM_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_sl && v_c[NUM_STAGES]) begin
			bcd_sl  <= bcd_c[NUM_STAGES];
			meta_sl <= meta_c[NUM_STAGES];
			len_sl  <= len_nx;
		end
	end

	// ---- character emitter with output register ----
	itda_emit #(
		.NUM_DIGITS (NUM_DIGITS),
		.LEN_W      (LEN_W)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_sl),
		.in_ready  (emit_ready),
		.in_bcd    (bcd_sl),
		.in_meta   (meta_sl),
		.in_len    (len_sl),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	// ---- assertions ----
	a_zero_width_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (field_width == '0)) |=> !v_s1)
		else $error("zero-width item entered the pipeline");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_sl |-> ((len_sl != '0) && (len_sl <= LEN_W'(NUM_DIGITS + 1))
			&& (len_sl >= LEN_W'(1) + LEN_W'(meta_sl.neg))))
		else $error("text length out of range");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((character == ASCII_SPACE) || (character == ASCII_MINUS)
			|| ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + 8'd9))))
		else $error("emitted character outside digit, minus and space");

	a_width_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (meta_s1.width != '0))
		else $error("zero field width reached conversion");

endmodule

>>> bench/itda_checker.sv
// Scoreboard for int_to_decimal_ascii_padded: predicts every field's characters from
// the accepted input items and compares them with the output channel.
// Depends on itda_pkg.
`timescale 1ns / 1ps

module itda_checker
	import itda_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [DEF_VALUE_BITS-1:0] value,
	input  logic [FW_W-1:0]           field_width,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [CHAR_W-1:0]         character,
	input  logic                      last,
	output int                        fail_count,
	output int                        outstanding_chars
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} field_char_t;

	field_char_t field_chars[$];
	int          errors = 0;

	// Decimal text, '-' first when negative, then cut or space-padded to the field.
	function automatic void format_field(input logic [DEF_VALUE_BITS-1:0] v,
			input logic [FW_W-1:0] fw);
		logic [CHAR_W-1:0]         text[$];
		logic [DEF_VALUE_BITS-1:0] mag;
		int                        w;
		field_char_t               fc;
		mag = v[DEF_VALUE_BITS-1] ? (~v + 1'b1) : v;
		do begin
			text.push_front(ASCII_ZERO + CHAR_W'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (v[DEF_VALUE_BITS-1])
			text.push_front(ASCII_MINUS);
		w = (int'(fw) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(fw);
		for (int k = 0; k < w; k++) begin
			fc.ch   = (k < text.size()) ? text[k] : ASCII_SPACE;
			fc.last = (k == w - 1);
			field_chars.push_back(fc);
		end
	endfunction

	always @(posedge clk) begin
		field_char_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (field_chars.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual %h last %b",
						$time, character, last);
					errors++;
				end else begin
					want = field_chars.pop_front();
					if (character !== want.ch) begin
						$display("%0t: character mismatch: expected %h, actual %h",
							$time, want.ch, character);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch: expected %b, actual %b",
							$time, want.last, last);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				format_field(value, field_width);
		end
		fail_count        <= errors;
		outstanding_chars <= field_chars.size();
	end

endmodule

>>> bench/tb_int_to_decimal_ascii_padded.sv
// Top of the int_to_decimal_ascii_padded bench: clock, reset, input items, output stalls
// and the verdict. Depends on itda_pkg, itda_checker and the block itself.
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii_padded;
	import itda_pkg::*;

	localparam int RANDOM_ITEMS = 430;
	localparam int DRAIN_CYCLES = 24;  // pipeline depth plus slack for dropped items

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                             clk         = 1'b0;
	logic                             arst_n      = 1'b0;
	logic                             in_valid    = 1'b0;
	logic                             in_stall;
	logic signed [DEF_VALUE_BITS-1:0] value       = '0;
	logic [FW_W-1:0]                  field_width = '0;
	logic                             out_valid;
	logic                             out_stall   = 1'b0;
	logic [CHAR_W-1:0]                character;
	logic                             last;

	int          fail_count;
	int          outstanding_chars;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	int_to_decimal_ascii_padded i_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.value,
		.field_width,
		.out_valid,
		.out_stall,
		.character,
		.last
	);

	itda_checker i_checker (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.value,
		.field_width,
		.out_valid,
		.out_stall,
		.character,
		.last,
		.fail_count,
		.outstanding_chars
	);

	// Receiver: picks a stall mode for a random stretch of cycles, so that stalls
	// land on every character position, including long stall-free runs.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
			STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
			default:        out_stall <= (stall_left[1:0] == 2'b00);
		endcase
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_item(input logic [DEF_VALUE_BITS-1:0] v, input int w);
		in_valid    <= 1'b1;
		value       <= v;
		field_width <= FW_W'(w);
		do @(posedge clk); while (in_stall);
	endtask

	// Sender idle cycles; payload carries junk while valid is low.
	task automatic pause(input int cycles);
		for (int c = 0; c < cycles; c++) begin
			in_valid    <= 1'b0;
			value       <= $urandom;
			field_width <= FW_W'($urandom);
			@(posedge clk);
		end
	endtask

	// Mix of full-range, small, scaled, near-extreme and power-of-ten values.
	function automatic logic [DEF_VALUE_BITS-1:0] random_value();
		int unsigned               pick;
		logic [DEF_VALUE_BITS-1:0] v;
		logic [DEF_VALUE_BITS-1:0] p;
		pick = $urandom_range(0, 99);
		p    = 1;
		if (pick < 35) begin
			v = $urandom;
		end else if (pick < 60) begin
			v = DEF_VALUE_BITS'($urandom_range(0, 1998)) - 999;
		end else if (pick < 80) begin
			v = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1))
				v = -v;
		end else if (pick < 90) begin
			if ($urandom_range(0, 1))
				v = 32'h8000_0000 + $urandom_range(0, 15);
			else
				v = 32'h7fff_ffff - $urandom_range(0, 15);
		end else begin
			// digit-count boundaries: 10^k - 1, 10^k, 10^k + 1
			repeat ($urandom_range(0, 9)) p = p * 10;
			v = p + $urandom_range(0, 2) - 1;
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	// Mostly typical widths, some wide, a few dropped or saturating ones.
	function automatic int random_width();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return 0;
		else if (pick < 70)
			return $urandom_range(1, 16);
		else if (pick < 92)
			return $urandom_range(17, 64);
		else
			return $urandom_range(65, 127);
	endfunction

	initial begin
		int sent;
		int burst;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: zero, sign only, exact fit, padding, truncation, the most
		// negative value, dropped zero-width items and widths above the limit.
		send_item(0, 1);
		send_item(0, 5);
		send_item(7, 1);
		send_item(-1, 2);
		send_item(-1, 1);
		send_item(32'h7fff_ffff, 10);
		send_item(32'h7fff_ffff, 14);
		send_item(32'h7fff_ffff, 3);
		pause(3);
		send_item(32'h8000_0000, 11);
		send_item(32'h8000_0000, 64);
		send_item(32'h8000_0000, 4);
		send_item(12345, 0);
		send_item(42, 0);
		send_item(99, 127);
		send_item(100, 65);
		pause(20);
		send_item(-10, 64);
		send_item(1000000000, 10);
		send_item(-999999999, 12);
		send_item(5, 2);
		send_item(-7, 3);
		send_item(9, 0);
		send_item(32'h5555_5555, 12);
		send_item(32'haaaa_aaaa, 13);
		pause(2);

		// Random bursts with random gaps; zero gap keeps valid high across bursts.
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				send_item(random_value(), random_width());
				sent++;
			end
			if ($urandom_range(0, 9) == 0)
				pause($urandom_range(20, 60));
			else if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 8));
		end
		pause(1);

		while (outstanding_chars != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("tb_int_to_decimal_ascii_padded: PASS");
		else
			$display("tb_int_to_decimal_ascii_padded: FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("tb_int_to_decimal_ascii_padded: FAIL");
		$finish;
	end

endmodule
